@@ hw/rtl/cell_protection_latch_core_defines.svh @@
// Assertion macros used by the cell protection latch core.
`ifndef CELL_PROTECTION_LATCH_CORE_DEFINES_SVH
`define CELL_PROTECTION_LATCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define CPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cell protection latch: same-cycle check failed");

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define CPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cell protection latch: next-cycle check failed");

`endif

@@ hw/rtl/cpl_pkg.sv @@
// Shared types and constants for the cell protection latch.
package cpl_pkg;

    localparam int CPL_MAX_CELLS = 16;
    localparam int CPL_IDX_W     = (CPL_MAX_CELLS > 1) ? $clog2(CPL_MAX_CELLS) : 1;
    localparam int CPL_COUNT_W   = $clog2(CPL_MAX_CELLS + 1);

    localparam int CPL_ID_W   = 8;
    localparam int CPL_VOLT_W = 16;
    localparam int CPL_TEMP_W = 12;
    localparam int CPL_REG_W  = 16;

    typedef logic [CPL_IDX_W-1:0]          idx_t;
    typedef logic [CPL_COUNT_W-1:0]        count_t;
    typedef logic [CPL_ID_W-1:0]           id_t;
    typedef logic [CPL_VOLT_W-1:0]         volt_t;
    typedef logic signed [CPL_TEMP_W-1:0]  temp_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_OV   = 2'd1,
        CAUSE_UV   = 2'd2,
        CAUSE_OT   = 2'd3
    } cause_t;

    typedef enum logic [1:0] {
        REG_OVER_VOLT  = 2'd0,
        REG_UNDER_VOLT = 2'd1,
        REG_OVER_TEMP  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        id_t   id;
        volt_t volt;
        temp_t temp;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic   hit;
        cause_t cause;
    } cmp_res_t;

endpackage

@@ hw/rtl/cpl_table.sv @@
// Cell table storage: one write port, one registered read port.
module cpl_table (
    input  logic             clk,
    input  cpl_pkg::mem_wr_t wr,
    input  logic             rd_en,
    input  cpl_pkg::idx_t    rd_addr,
    output cpl_pkg::entry_t  rd_data
);
    import cpl_pkg::*;

    entry_t mem [CPL_MAX_CELLS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cpl_cmp.sv @@
// Shared compare unit: id match or ordered threshold test on one entry.
module cpl_cmp (
    input  cpl_pkg::entry_t   ent,
    input  logic              check_mode,
    input  cpl_pkg::id_t      key,
    input  cpl_pkg::volt_t    over_volt,
    input  cpl_pkg::volt_t    under_volt,
    input  cpl_pkg::temp_t    over_temp,
    output cpl_pkg::cmp_res_t res
);
    import cpl_pkg::*;

    always_comb
    begin
        res.hit   = 1'b0;
        res.cause = CAUSE_NONE;
        if (check_mode)
        begin
            // over-voltage wins over under-voltage, which wins over temperature
            if (ent.volt > over_volt)
            begin
                res.hit   = 1'b1;
                res.cause = CAUSE_OV;
            end
            else if (ent.volt < under_volt)
            begin
                res.hit   = 1'b1;
                res.cause = CAUSE_UV;
            end
            else if (ent.temp > over_temp)
            begin
                res.hit   = 1'b1;
                res.cause = CAUSE_OT;
            end
        end
        else
        begin
            res.hit = (ent.id == key);
        end
    end

endmodule

@@ hw/rtl/cell_protection_latch_core.sv @@
// Top level of the cell protection latch: sequencer, latch and status output.
// Battery cell protection with a latched fault. The block holds a table of up
// to sixteen cells (id, millivolts, signed tenths of a degree). Each transfer on
// the input channel carries one command and produces exactly one status transfer
// on the output channel. An add, a no-op, an update of an empty table and a check
// that has nothing to walk go from the idle state straight to the done state and
// from there into the output register. An update or a safety check walks the used
// entries in table order through a single shared compare unit, one entry per cycle,
// fed by the registered read port of the table memory, and then passes through the
// done state into the output register. The next command is not taken until the
// last one has left the done state. A check stops at the first cell over voltage,
// under voltage or over temperature (tested in that order), clears contactor_closed
// and latches the cause and cell id until reset; once latched, checks do nothing.
// in_stall is high while a command is being worked on. The finished status sits in
// an output register, so the next command may be taken while it still waits for the
// consumer. The user must write thresholds through the wr_en / wr_index / wr_data
// port only while the block is idle; the block itself does not enforce this.
// wr_index 3 is ignored. The table needs no clearing pass: only entries below
// cell_count are ever used.
`include "cell_protection_latch_core_defines.svh"

module cell_protection_latch_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // threshold write port
    input  logic                                   wr_en,
    input  logic [1:0]                             wr_index,
    input  logic [cpl_pkg::CPL_REG_W-1:0]          wr_data,
    // command channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             opcode,
    input  logic [cpl_pkg::CPL_ID_W-1:0]           cell_id,
    input  logic [cpl_pkg::CPL_VOLT_W-1:0]         cell_voltage,
    input  logic signed [cpl_pkg::CPL_TEMP_W-1:0]  cell_temp,
    // status channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   contactor_closed,
    output logic [1:0]                             fault_cause,
    output logic [cpl_pkg::CPL_ID_W-1:0]           fault_cell,
    output logic                                   add_rejected,
    output logic [cpl_pkg::CPL_COUNT_W-1:0]        cell_count
);
    import cpl_pkg::*;

    // sequencer
    state_t   state_reg, state_next;
    idx_t     idx_reg, idx_next;

    // command held for the duration of a walk
    op_t      op_reg, op_next;
    id_t      id_reg, id_next;
    volt_t    volt_reg, volt_next;
    temp_t    temp_reg, temp_next;
    logic     rej_reg, rej_next;

    // architectural state
    count_t   count_reg, count_next;
    logic     safe_reg, safe_next;
    cause_t   cause_reg, cause_next;
    id_t      fcell_reg, fcell_next;

    // thresholds
    volt_t    ov_reg, uv_reg;
    temp_t    ot_reg;

    // output register
    logic     out_valid_reg, out_valid_next;
    logic     out_safe_reg;
    cause_t   out_cause_reg;
    id_t      out_cell_reg;
    logic     out_rej_reg;
    count_t   out_count_reg;

    // datapath controls
    mem_wr_t  mem_wr;
    logic     rd_en;
    idx_t     rd_addr;
    entry_t   rd_data;
    cmp_res_t cmp_res;
    logic     in_xfer;
    logic     out_free;
    logic     load_out;
    logic     last_entry;
    op_t      in_op;

    assign in_op      = op_t'(opcode);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign last_entry = (count_t'(idx_reg) + count_t'(1)) == count_reg;

    cpl_table u_table (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cpl_cmp u_cmp (
        .ent        (rd_data),
        .check_mode (op_reg == OP_CHECK),
        .key        (id_reg),
        .over_volt  (ov_reg),
        .under_volt (uv_reg),
        .over_temp  (ot_reg),
        .res        (cmp_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // walk only when there is something to walk
                    if (((in_op == OP_UPDATE) && (count_reg != '0)) ||
                        ((in_op == OP_CHECK) && safe_reg && (count_reg != '0)))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp_res.hit || last_entry)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        idx_next     = idx_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        volt_next    = volt_reg;
        temp_next    = temp_reg;
        rej_next     = rej_reg;
        count_next   = count_reg;
        safe_next    = safe_reg;
        cause_next   = cause_reg;
        fcell_next   = fcell_reg;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = idx_reg;
        mem_wr.data  = rd_data;
        rd_en        = 1'b0;
        rd_addr      = '0;
        load_out     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next   = in_op;
                    id_next   = cell_id;
                    volt_next = cell_voltage;
                    temp_next = cell_temp;
                    rej_next  = 1'b0;
                    idx_next  = '0;
                    // prefetch entry zero for a walk
                    rd_en     = 1'b1;
                    if (in_op == OP_ADD)
                    begin
                        if (count_reg < count_t'(CPL_MAX_CELLS))
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = count_reg[CPL_IDX_W-1:0];
                            mem_wr.data = '{id: cell_id, volt: cell_voltage,
                                            temp: cell_temp};
                            count_next  = count_reg + count_t'(1);
                        end
                        else
                        begin
                            rej_next = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // advance the read one entry ahead of the compare
                rd_en    = 1'b1;
                rd_addr  = idx_reg + idx_t'(1);
                idx_next = idx_reg + idx_t'(1);
                if (cmp_res.hit)
                begin
                    if (op_reg == OP_CHECK)
                    begin
                        safe_next  = 1'b0;
                        cause_next = cmp_res.cause;
                        fcell_next = rd_data.id;
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = idx_reg;
                        mem_wr.data = '{id: rd_data.id, volt: volt_reg, temp: temp_reg};
                    end
                end
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            safe_reg      <= 1'b1;
            cause_reg     <= CAUSE_NONE;
            fcell_reg     <= '0;
            out_valid_reg <= 1'b0;
            ov_reg        <= volt_t'(4200);
            uv_reg        <= volt_t'(3000);
            ot_reg        <= temp_t'(600);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            safe_reg      <= safe_next;
            cause_reg     <= cause_next;
            fcell_reg     <= fcell_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_OVER_VOLT:  ov_reg <= wr_data[CPL_VOLT_W-1:0];
                    REG_UNDER_VOLT: uv_reg <= wr_data[CPL_VOLT_W-1:0];
                    REG_OVER_TEMP:  ot_reg <= temp_t'(wr_data[CPL_TEMP_W-1:0]);
                    default:        ov_reg <= ov_reg;
                endcase
            end
        end
    end

    // held command and output payload
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        id_reg   <= id_next;
        volt_reg <= volt_next;
        temp_reg <= temp_next;
        rej_reg  <= rej_next;
        if (load_out)
        begin
            out_safe_reg  <= safe_reg;
            out_cause_reg <= cause_reg;
            out_cell_reg  <= fcell_reg;
            out_rej_reg   <= rej_reg;
            out_count_reg <= count_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign contactor_closed = out_safe_reg;
    assign fault_cause      = out_cause_reg;
    assign fault_cell       = out_cell_reg;
    assign add_rejected     = out_rej_reg;
    assign cell_count       = out_count_reg;

    // a latched fault holds until reset
    `CPL_ASSERT_NEXT(a_fault_sticky, !safe_reg, !safe_reg)
    // no cause is reported while the system is safe
    `CPL_ASSERT_NOW(a_safe_no_cause, safe_reg, cause_reg == CAUSE_NONE)
    // the table never holds more than its capacity
    `CPL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= count_t'(CPL_MAX_CELLS))
    // a taken command always leaves the idle state
    `CPL_ASSERT_NEXT(a_cmd_starts, in_valid && !in_stall, state_reg != ST_IDLE)

endmodule
